[rtl/dre_pkg.sv]
package dre_pkg;

  localparam int unsigned DefaultValueBits = 31;
  // Quotient bits retired per divider cycle
  localparam int unsigned SliceBits = 8;

  localparam int unsigned BaseBits  = 6;
  localparam int unsigned DigitBits = 6;
  localparam int unsigned CharBits  = 7;

  localparam logic [BaseBits-1:0]  MinBase   = 6'd2;
  localparam logic [BaseBits-1:0]  MaxBase   = 6'd36;
  localparam logic [BaseBits-1:0]  ResetBase = 6'd2;
  localparam logic [DigitBits-1:0] DecDigits = 6'd10;
  localparam logic [CharBits-1:0]  AsciiZero = 7'd48;
  localparam logic [CharBits-1:0]  AsciiA    = 7'd65;

  // Queue status seen by front and back
  typedef struct packed {
    logic has_space;
    logic has_data;
  } q_stat_t;

  function automatic logic [BaseBits-1:0] eff_base(input logic [BaseBits-1:0] b);
    logic [BaseBits-1:0] r;
    if (b < MinBase) begin
      r = MinBase;
    end else if (b > MaxBase) begin
      r = MaxBase;
    end else begin
      r = b;
    end
    return r;
  endfunction

  function automatic logic [CharBits-1:0] to_ascii(input logic [DigitBits-1:0] d);
    logic [CharBits-1:0] c;
    if (d < DecDigits) begin
      c = AsciiZero + CharBits'(d);
    end else begin
      c = AsciiA + CharBits'(d - DecDigits);
    end
    return c;
  endfunction

endpackage

[rtl/dre_front.sv]
module dre_front #(
  parameter int unsigned VALUE_BITS = dre_pkg::DefaultValueBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [dre_pkg::BaseBits-1:0]   base_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [VALUE_BITS-1:0]          value_i,
  input  logic                           q_space_i,
  output logic                           wr_en_o,
  output logic [$clog2(VALUE_BITS)-1:0]  wr_idx_o,
  output logic [dre_pkg::DigitBits-1:0]  wr_digit_o,
  output logic                           push_o,
  output logic [$clog2(VALUE_BITS+1)-1:0] push_cnt_o
);

  localparam int unsigned IdxW   = $clog2(VALUE_BITS);
  localparam int unsigned CntW   = $clog2(VALUE_BITS + 1);
  localparam int unsigned Slice  = dre_pkg::SliceBits;
  localparam int unsigned Chunks = (VALUE_BITS + Slice - 1) / Slice;
  localparam int unsigned QW     = Chunks * Slice;
  localparam int unsigned ChunkW = (Chunks > 1) ? $clog2(Chunks) : 1;
  localparam int unsigned BW     = dre_pkg::BaseBits;

  localparam logic FS_IDLE = 1'b0;
  localparam logic FS_DIV  = 1'b1;

  logic              state_q, state_d;
  logic [QW-1:0]     quo_q, quo_d;
  logic [BW-1:0]     base_q, base_d;
  logic [BW-1:0]     rem_q, rem_d;
  logic [ChunkW-1:0] chunk_q, chunk_d;
  logic [CntW-1:0]   n_q, n_d;

  logic [BW-1:0]     rem_nx;
  logic [Slice-1:0]  qbits;
  logic [QW-1:0]     quo_nx;
  logic              last_chunk;
  logic              accept;

  // Restoring division, Slice quotient bits per cycle, MSB chunk first
  always_comb begin
    logic [BW:0]   t;
    logic [BW-1:0] r;
    r     = rem_q;
    qbits = '0;
    for (int unsigned j = 0; j < Slice; j++) begin
      t = {r, quo_q[QW-1-j]};
      if (t >= {1'b0, base_q}) begin
        t              = t - {1'b0, base_q};
        qbits[Slice-1-j] = 1'b1;
      end
      r = t[BW-1:0];
    end
    rem_nx = r;
    quo_nx = (quo_q << Slice) | QW'(qbits);
  end

  assign last_chunk = (chunk_q == ChunkW'(Chunks - 1));
  assign in_ready_o = (state_q == FS_IDLE) && q_space_i;
  assign accept     = in_valid_i && in_ready_o;

  assign wr_en_o    = (state_q == FS_DIV) && last_chunk;
  assign wr_idx_o   = n_q[IdxW-1:0];
  assign wr_digit_o = rem_nx;
  assign push_o     = wr_en_o && (quo_nx == '0);
  assign push_cnt_o = n_q + CntW'(1);

  always_comb begin
    state_d = state_q;
    quo_d   = quo_q;
    base_d  = base_q;
    rem_d   = rem_q;
    chunk_d = chunk_q;
    n_d     = n_q;
    unique case (state_q)
      FS_IDLE: begin
        if (accept) begin
          state_d = FS_DIV;
          quo_d   = QW'(value_i);
          base_d  = dre_pkg::eff_base(base_i);
          rem_d   = '0;
          chunk_d = '0;
          n_d     = '0;
        end
      end
      FS_DIV: begin
        quo_d = quo_nx;
        if (last_chunk) begin
          rem_d   = '0;
          chunk_d = '0;
          n_d     = n_q + CntW'(1);
          if (quo_nx == '0) begin
            state_d = FS_IDLE;
          end
        end else begin
          rem_d   = rem_nx;
          chunk_d = chunk_q + ChunkW'(1);
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      chunk_q <= '0;
      n_q     <= '0;
      quo_q   <= '0;
    end else begin
      state_q <= state_d;
      chunk_q <= chunk_d;
      n_q     <= n_d;
      quo_q   <= quo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    rem_q  <= rem_d;
  end

endmodule

[rtl/dre_queue.sv]
module dre_queue #(
  parameter int unsigned VALUE_BITS = dre_pkg::DefaultValueBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [$clog2(VALUE_BITS)-1:0]   wr_idx_i,
  input  logic [dre_pkg::DigitBits-1:0]   wr_digit_i,
  input  logic                            push_i,
  input  logic [$clog2(VALUE_BITS+1)-1:0] push_cnt_i,
  input  logic                            rd_en_i,
  input  logic [$clog2(VALUE_BITS)-1:0]   rd_idx_i,
  output logic [dre_pkg::DigitBits-1:0]   rd_digit_o,
  input  logic                            pop_i,
  output logic [$clog2(VALUE_BITS+1)-1:0] cnt_o,
  output dre_pkg::q_stat_t                stat_o
);

  localparam int unsigned IdxW  = $clog2(VALUE_BITS);
  localparam int unsigned CntW  = $clog2(VALUE_BITS + 1);
  localparam int unsigned Depth = 2 * (2 ** IdxW);

  // Two string slots, each one digit string of up to VALUE_BITS digits
  logic [dre_pkg::DigitBits-1:0] mem_q [Depth];
  logic [dre_pkg::DigitBits-1:0] rdata_q;
  logic [CntW-1:0]               cnt_q [2];
  logic                          wp_q, rp_q;
  logic [1:0]                    occ_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[{wp_q, wr_idx_i}] <= wr_digit_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[{rp_q, rd_idx_i}];
    end
    if (push_i) begin
      cnt_q[wp_q] <= push_cnt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      occ_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      if (push_i && !pop_i) begin
        occ_q <= occ_q + 2'd1;
      end else if (pop_i && !push_i) begin
        occ_q <= occ_q - 2'd1;
      end
    end
  end

  assign rd_digit_o       = rdata_q;
  assign cnt_o            = cnt_q[rp_q];
  assign stat_o.has_space = (occ_q != 2'd2);
  assign stat_o.has_data  = (occ_q != 2'd0);

endmodule

[rtl/dre_back.sv]
module dre_back #(
  parameter int unsigned VALUE_BITS = dre_pkg::DefaultValueBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_data_i,
  input  logic [$clog2(VALUE_BITS+1)-1:0] cnt_i,
  output logic                            rd_en_o,
  output logic [$clog2(VALUE_BITS)-1:0]   rd_idx_o,
  input  logic [dre_pkg::DigitBits-1:0]   rd_digit_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dre_pkg::CharBits-1:0]    digit_char_o,
  output logic                            last_digit_o
);

  localparam int unsigned IdxW = $clog2(VALUE_BITS);
  localparam int unsigned CntW = $clog2(VALUE_BITS + 1);

  logic                         active_q;
  logic [IdxW-1:0]              idx_q;
  logic                         pend_q, pend_last_q;
  logic                         ovalid_q;
  logic [dre_pkg::CharBits-1:0] ochar_q;
  logic                         olast_q;
  logic                         issue;
  logic [CntW-1:0]              top;

  // One read in flight at most; it lands in a free output register
  assign issue    = active_q && !pend_q && (!ovalid_q || out_ready_i);
  assign rd_en_o  = issue;
  assign rd_idx_o = idx_q;
  assign pop_o    = issue && (idx_q == '0);
  assign top      = cnt_i - CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      pend_q <= issue;
      if (!active_q && q_data_i) begin
        active_q <= 1'b1;
      end else if (pop_o) begin
        active_q <= 1'b0;
      end
      if (pend_q) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!active_q && q_data_i) begin
      idx_q <= top[IdxW-1:0];
    end else if (issue) begin
      idx_q <= idx_q - IdxW'(1);
    end
    if (issue) begin
      pend_last_q <= (idx_q == '0);
    end
    if (pend_q) begin
      ochar_q <= dre_pkg::to_ascii(rd_digit_i);
      olast_q <= pend_last_q;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign digit_char_o = ochar_q;
  assign last_digit_o = olast_q;

endmodule

[rtl/radix_digit_emitter.sv]
// Channel   Direction  Handshake                  Payload
// value     in         in_valid_i / in_ready_o    value_i [VALUE_BITS]
// digits    out        out_valid_o / out_ready_i  digit_char_o [7], last_digit_o
// config    in         cfg_we_i (no wait)         cfg_wdata_i [6] -> target base
//
// Front: restoring divider retiring 8 quotient bits a cycle; it takes no new
// item until every digit of the current one is written. Back: the read of the
// digit memory is registered and only one read is in flight, so the next read
// waits until the previous digit has landed in the output register. Two string
// slots between them let the front divide the next item while the back still
// streams the previous one.
// Reset is asynchronous active low; no clearing pass. Output stalls back up only
// into the back part until both slots are full, then in_ready_o drops.
module radix_digit_emitter #(
  parameter int unsigned VALUE_BITS = dre_pkg::DefaultValueBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dre_pkg::BaseBits-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [VALUE_BITS-1:0]         value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dre_pkg::CharBits-1:0]  digit_char_o,
  output logic                          last_digit_o
);

  localparam int unsigned IdxW = $clog2(VALUE_BITS);
  localparam int unsigned CntW = $clog2(VALUE_BITS + 1);

  // Target base register, clamped to 2..36 when an item starts
  logic [dre_pkg::BaseBits-1:0] base_q;

  dre_pkg::q_stat_t              stat;
  logic                          wr_en;
  logic [IdxW-1:0]               wr_idx;
  logic [dre_pkg::DigitBits-1:0] wr_digit;
  logic                          push;
  logic [CntW-1:0]               push_cnt;
  logic                          rd_en;
  logic [IdxW-1:0]               rd_idx;
  logic [dre_pkg::DigitBits-1:0] rd_digit;
  logic                          pop;
  logic [CntW-1:0]               cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= dre_pkg::ResetBase;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // Front: takes a request, divides repeatedly, writes digits LSB first
  dre_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .base_i     (base_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .q_space_i  (stat.has_space),
    .wr_en_o    (wr_en),
    .wr_idx_o   (wr_idx),
    .wr_digit_o (wr_digit),
    .push_o     (push),
    .push_cnt_o (push_cnt)
  );

  // Two-slot digit string queue
  dre_queue #(
    .VALUE_BITS (VALUE_BITS)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_idx_i   (wr_idx),
    .wr_digit_i (wr_digit),
    .push_i     (push),
    .push_cnt_i (push_cnt),
    .rd_en_i    (rd_en),
    .rd_idx_i   (rd_idx),
    .rd_digit_o (rd_digit),
    .pop_i      (pop),
    .cnt_o      (cnt),
    .stat_o     (stat)
  );

  // Back: reads digits MSB first, maps to ASCII, flags the last one
  dre_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_data_i     (stat.has_data),
    .cnt_i        (cnt),
    .rd_en_o      (rd_en),
    .rd_idx_o     (rd_idx),
    .rd_digit_i   (rd_digit),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ValueBits     = dre_pkg::DefaultValueBits;
  localparam logic [ValueBits-1:0] MaxValue = '1;
  localparam int unsigned PhaseCount    = 10;
  localparam int unsigned PhaseRequests = 41;
  // worst digit string: 31 digits
  localparam int unsigned SettleCycles  = 150;
  localparam int unsigned WatchdogLimit = 2000;

  // receiver back-pressure styles
  typedef enum int unsigned {
    ReadyAlways,
    ReadyCoin,
    ReadySparse,
    ReadyHold
  } rx_mode_e;

  typedef struct packed {
    logic [dre_pkg::CharBits-1:0] ch;
    logic                         last;
  } digit_t;

  // Expands each accepted value into its expected digit string and checks
  // the digits the block emits against it, oldest first.
  class radix_scoreboard;
    logic [dre_pkg::BaseBits-1:0] base_reg = dre_pkg::ResetBase;
    digit_t                       digit_queue[$];
    int unsigned                  errors = 0;

    function void set_base(logic [dre_pkg::BaseBits-1:0] b);
      base_reg = b;
    endfunction

    // out-of-range settings clamp to the nearest legal radix
    function int unsigned radix();
      int unsigned r;
      r = base_reg;
      if (r < dre_pkg::MinBase) r = dre_pkg::MinBase;
      if (r > dre_pkg::MaxBase) r = dre_pkg::MaxBase;
      return r;
    endfunction

    function void note_request(logic [ValueBits-1:0] v);
      int unsigned                   b;
      logic [ValueBits-1:0]          quo;
      logic [dre_pkg::DigitBits-1:0] digs[$];
      digit_t                        e;
      b   = radix();
      quo = v;
      // zero still yields one digit
      do begin
        digs.push_front(dre_pkg::DigitBits'(quo % b));
        quo = quo / b;
      end while (quo != 0);
      foreach (digs[i]) begin
        if (digs[i] < dre_pkg::DecDigits) begin
          e.ch = dre_pkg::AsciiZero + dre_pkg::CharBits'(digs[i]);
        end else begin
          e.ch = dre_pkg::AsciiA + dre_pkg::CharBits'(digs[i] - dre_pkg::DecDigits);
        end
        e.last = (i == digs.size() - 1);
        digit_queue.push_back(e);
      end
    endfunction

    function void check_digit(logic [dre_pkg::CharBits-1:0] ch, logic last);
      digit_t e;
      if (digit_queue.size() == 0) begin
        $error("unexpected digit: digit_char %0d last_digit %0d", ch, last);
        errors++;
        return;
      end
      e = digit_queue.pop_front();
      if (ch !== e.ch) begin
        $error("digit_char: expected %0d actual %0d", e.ch, ch);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_digit: expected %0d actual %0d", e.last, last);
        errors++;
      end
    endfunction

    function int unsigned digits_due();
      return digit_queue.size();
    endfunction
  endclass

  // all inputs known from time zero
  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [dre_pkg::BaseBits-1:0]  cfg_wdata_i = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [ValueBits-1:0]          value_i     = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [dre_pkg::CharBits-1:0]  digit_char_o;
  logic                          last_digit_o;

  radix_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  rx_mode_e    rx_mode = ReadyAlways;
  int unsigned rx_mode_left = 0;
  int unsigned rx_hold_left = 0;
  logic        rx_hold_level = 1'b0;

  radix_digit_emitter #(
    .VALUE_BITS(ValueBits)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .digit_char_o(digit_char_o),
    .last_digit_o(last_digit_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Drive one request; valid is left high so back-to-back requests need no
  // drop. The expected digits are queued at the accepting edge.
  task automatic send_value(logic [ValueBits-1:0] v);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    value_i    = v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(v);
  endtask

  task automatic sender_gap(int unsigned cycles);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    value_i    = ValueBits'($urandom);
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Stop sending and wait until every outstanding digit has come out.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.digits_due() != 0) @(posedge clk_i);
  endtask

  // Only called with the block drained.
  task automatic write_base(logic [dre_pkg::BaseBits-1:0] b);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = b;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = dre_pkg::BaseBits'($urandom);
    sb.set_base(b);
  endtask

  // Mix of values: zero, all ones, tiny values, powers of the radix and the values
  // just below them, values of random length, and full-width noise.
  function automatic logic [ValueBits-1:0] pick_value();
    int unsigned     b;
    longint unsigned p;
    int unsigned     k;
    logic [ValueBits-1:0] v;
    b = sb.radix();
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = MaxValue;
      2, 3: v = ValueBits'($urandom_range(0, 2 * b));
      4: begin
        p = 1;
        k = $urandom_range(0, 31);
        repeat (k) if (p * b <= MaxValue) p = p * b;
        v = ValueBits'(p - $urandom_range(0, 1));
      end
      5, 6: v = ValueBits'($urandom) >> $urandom_range(0, ValueBits - 1);
      default: v = ValueBits'($urandom);
    endcase
    return v;
  endfunction

  // Directed part: range ends of the value and clamping of the radix.
  task automatic run_directed();
    send_value('0);
    send_value(31'd1);
    send_value(MaxValue);
    send_value(31'h4000_0000);
    drain();
    write_base(6'd0);      // below range, acts as base 2
    send_value(31'd5);
    drain();
    write_base(6'd1);
    send_value(31'd3);
    drain();
    write_base(dre_pkg::MaxBase);
    send_value('0);
    send_value(31'd35);    // single 'Z'
    send_value(31'd36);
    send_value(MaxValue);
    drain();
    write_base(6'd37);     // above range, acts as base 36
    send_value(31'd35);
    drain();
    write_base(6'd63);
    send_value(31'd1295);
    drain();
    write_base(6'd10);
    send_value('0);
    send_value(31'd9);
    send_value(31'd10);
    send_value(31'd1_000_000_000);
    send_value(MaxValue);
    drain();
    write_base(6'd16);
    send_value(31'h7EDC_BA98);
    send_value(31'h0ABC_DEF1);
    drain();
  endtask

  task automatic run_random();
    logic [dre_pkg::BaseBits-1:0] b;
    int unsigned                  pause_at;
    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      if (ph == 0)      b = dre_pkg::MaxBase;
      else if (ph == 1) b = dre_pkg::MinBase;
      else              b = dre_pkg::BaseBits'($urandom_range(0, 63));
      write_base(b);
      pause_at = $urandom_range(5, PhaseRequests - 5);
      for (int unsigned i = 0; i < PhaseRequests; i++) begin
        if (i == pause_at) drain();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          // one gap in four is skipped, giving long unbroken runs
          if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 30));
        end
        burst_left--;
        send_value(pick_value());
      end
      drain();
    end
  endtask

  // Receiver stalls follow a mode that is picked anew at random once its hold count runs out.
  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 300);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      ReadyAlways: out_ready_i = 1'b1;
      ReadyCoin:   out_ready_i = $urandom_range(0, 1);
      ReadySparse: out_ready_i = ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold_left == 0) begin
          rx_hold_level = ~rx_hold_level;
          rx_hold_left  = $urandom_range(1, 40);
        end else begin
          rx_hold_left--;
        end
        out_ready_i = rx_hold_level;
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_digit(digit_char_o, last_digit_o);
  end

  // Ends the run when no request or digit moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("[radix_digit_emitter] ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    run_directed();
    run_random();
    drain();
    // extra digits after the last expected one would show up here
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.digits_due() != 0) begin
      $error("%0d expected digits never came out", sb.digits_due());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[radix_digit_emitter] OK");
    end else begin
      $display("[radix_digit_emitter] ERROR");
    end
    $finish;
  end

endmodule
